### rtl/i2crtm_pkg.sv
// Package for the I2C register transaction master: phase codes, opcodes,
// register indexes, reset values and the result item type.
// No dependencies.
`timescale 1ns / 1ps

package i2crtm_pkg;

   // Write buffer depth default
   localparam int unsigned MAX_LEN_DEF = 256;

   // Item opcodes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_PUSH  = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;

   // Register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_DEV_ADDR = 2'd0;
   localparam logic [1:0] REG_HALF_PER = 2'd1;
   localparam logic [1:0] REG_ACK_TO   = 2'd2;

   localparam int unsigned CSR_AW = 4;
   localparam int unsigned CSR_DW = 32;

   // Register reset values
   localparam logic [6:0] DEV_ADDR_RST = 7'd93;
   localparam logic [7:0] HALF_PER_RST = 8'd2;
   localparam logic [7:0] ACK_TO_RST   = 8'd250;

   // Bus sequencer phases
   localparam logic [4:0] PH_IDLE    = 5'd0;
   localparam logic [4:0] PH_START_A = 5'd1;
   localparam logic [4:0] PH_START_B = 5'd2;
   localparam logic [4:0] PH_RESTART = 5'd3;
   localparam logic [4:0] PH_HDR_LO  = 5'd4;
   localparam logic [4:0] PH_HDR_HI  = 5'd5;
   localparam logic [4:0] PH_DAT_LO  = 5'd6;
   localparam logic [4:0] PH_DAT_HI  = 5'd7;
   localparam logic [4:0] PH_HACK_LO = 5'd8;
   localparam logic [4:0] PH_HACK_HI = 5'd9;
   localparam logic [4:0] PH_DACK_LO = 5'd10;
   localparam logic [4:0] PH_DACK_HI = 5'd11;
   localparam logic [4:0] PH_RX_LO   = 5'd12;
   localparam logic [4:0] PH_RX_HI   = 5'd13;
   localparam logic [4:0] PH_MACK_LO = 5'd14;
   localparam logic [4:0] PH_MACK_HI = 5'd15;
   localparam logic [4:0] PH_STOP_A  = 5'd16;
   localparam logic [4:0] PH_STOP_B  = 5'd17;
   localparam logic [4:0] PH_STOP_C  = 5'd18;

   // One result item
   typedef struct packed {
      logic       read_last;
      logic       read_valid;
      logic       error;
      logic       done_res;
      logic [7:0] read_byte;
      logic       busy_res;
      logic       sda_low;
      logic       scl;
   } rsp_item_type;

endpackage

### rtl/i2c_register_transaction_master.sv
// I2C master running 16-bit register address transactions, one bus step per
// half period of tick items, with a write byte buffer and a two-entry result queue.
// Depends on i2crtm_pkg.
`timescale 1ns / 1ps

//  channel | dir | handshake               | payload
//  req     | in  | req_tvalid / req_tready | tdata: sda_in, write_byte, is_read,
//          |     |                         |   reg_addr, length; tuser: opcode
//  rsp     | out | rsp_tvalid / rsp_tready | tdata: scl, sda_low, busy_res,
//          |     |                         |   read_byte, done_res, error;
//          |     |                         |   tuser: read_valid; tlast: read_last
//  csr     | in  | APB write/read          | device_address, half_period_ticks,
//          |     |                         |   ack_timeout at 0x0, 0x4, 0x8
//
// Every accepted item yields one registered result item; an item can be taken
// each cycle while the skid entry is free. The sequencer state updates in one
// pass of logic. The write buffer is a 1R1W memory; its read port prefetches the
// next byte. Reset clears the sequencer, the fill count and the result queue.
// A stalled result side is absorbed by a skid entry; req_tready drops only
// when both result entries are occupied.

module i2c_register_transaction_master #(
   parameter int unsigned MAX_LEN = i2crtm_pkg::MAX_LEN_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [0] sda_in, [8:1] write_byte, [9] is_read, [25:10] reg_addr,
   // [33:26] length, [39:34] zero
   input  logic [39:0]                     req_tdata,
   // [1:0] opcode
   input  logic [1:0]                      req_tuser,
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] scl, [1] sda_low, [2] busy_res, [10:3] read_byte, [11] done_res,
   // [12] error, [15:13] zero
   output logic [15:0]                     rsp_tdata,
   // [0] read_valid
   output logic                            rsp_tuser,
   output logic                            rsp_tlast,
   // configuration port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [i2crtm_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [i2crtm_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [i2crtm_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                            csr_pready
);
   import i2crtm_pkg::*;

   localparam int unsigned AW        = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam logic [8:0]  MAX_LEN_W = 9'(MAX_LEN);

   // configuration registers
   logic [6:0] dev_addr_ff;
   logic [7:0] half_per_ff;
   logic [7:0] ack_to_ff;

   // sequencer state
   logic [4:0] phase_ff,      phase_in;
   logic [7:0] tick_ff,       tick_in;
   logic [3:0] bit_ff,        bit_in;
   logic [7:0] shift_ff,      shift_in;
   logic [7:0] byte_cnt_ff,   byte_cnt_in;
   logic [7:0] ack_wait_ff,   ack_wait_in;
   logic [15:0] addr_ff,      addr_in;
   logic [7:0] len_ff,        len_in;
   logic       dir_ff,        dir_in;
   logic [7:0] fill_ff,       fill_in;
   logic       fail_ff,       fail_in;

   // write buffer
   logic [7:0]    wbuf_mem [MAX_LEN];
   logic          wbuf_we;
   logic [AW-1:0] wbuf_raddr;
   logic [7:0]    wbuf_rdata_ff;

   // result queue
   rsp_item_type out_ff,  skid_ff, res_in;
   logic         out_v_ff, skid_v_ff;

   // request fields
   logic        acc;
   logic [1:0]  op;
   logic        sda;
   logic [7:0]  wr_byte;
   logic        is_rd;
   logic [15:0] reg_addr;
   logic [7:0]  length;

   // step helpers
   logic       busy;
   logic       more;
   logic [7:0] span;
   logic [8:0] tick_nxt;
   logic [8:0] tries;
   logic [7:0] bc_nxt;
   logic [3:0] bit_nxt;
   logic [7:0] rx_shift;
   logic       room;

   assign acc      = req_tvalid & req_tready;
   assign op       = req_tuser;
   assign sda      = req_tdata[0];
   assign wr_byte  = req_tdata[8:1];
   assign is_rd    = req_tdata[9];
   assign reg_addr = req_tdata[25:10];
   assign length   = req_tdata[33:26];

   assign req_tready = ~skid_v_ff;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= DEV_ADDR_RST;
         half_per_ff <= HALF_PER_RST;
         ack_to_ff   <= ACK_TO_RST;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         unique case (csr_paddr[3:2])
            REG_DEV_ADDR: dev_addr_ff <= csr_pwdata[6:0];
            REG_HALF_PER: half_per_ff <= csr_pwdata[7:0];
            REG_ACK_TO:   ack_to_ff   <= csr_pwdata[7:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_DEV_ADDR: csr_prdata = {25'd0, dev_addr_ff};
         REG_HALF_PER: csr_prdata = {24'd0, half_per_ff};
         REG_ACK_TO:   csr_prdata = {24'd0, ack_to_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // ---------------- write buffer ----------------
   // Prefetch: byte 0 during header acks, the next data byte during data acks
   assign wbuf_raddr = (phase_ff == PH_DACK_LO || phase_ff == PH_DACK_HI)
                       ? AW'(byte_cnt_ff + 8'd1) : '0;

   always_ff @(posedge clock) begin
      if (wbuf_we) begin
         wbuf_mem[fill_ff[AW-1:0]] <= wr_byte;
      end
      wbuf_rdata_ff <= wbuf_mem[wbuf_raddr];
   end

   // ---------------- sequencer step ----------------
   assign busy     = (phase_ff != PH_IDLE);
   assign more     = ({1'b0, byte_cnt_ff} + 9'd1) < {1'b0, len_ff};
   assign span     = (half_per_ff == 8'd0) ? 8'd1 : half_per_ff;
   assign tick_nxt = {1'b0, tick_ff} + 9'd1;
   assign tries    = {1'b0, ack_wait_ff} + 9'd1;
   assign bc_nxt   = byte_cnt_ff + 8'd1;
   assign bit_nxt  = bit_ff + 4'd1;
   assign rx_shift = {shift_ff[6:0], sda};
   assign room     = ({1'b0, fill_ff} < MAX_LEN_W) && (fill_ff != 8'hFF);

   always_comb begin
      phase_in    = phase_ff;
      tick_in     = tick_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      byte_cnt_in = byte_cnt_ff;
      ack_wait_in = ack_wait_ff;
      addr_in     = addr_ff;
      len_in      = len_ff;
      dir_in      = dir_ff;
      fill_in     = fill_ff;
      fail_in     = fail_ff;
      wbuf_we     = 1'b0;

      res_in            = '0;
      res_in.busy_res   = busy;
      res_in.scl        = 1'b1;
      res_in.sda_low    = 1'b0;

      // line levels come from the state before the item
      case (phase_ff)
         PH_START_B: begin res_in.scl = 1'b1; res_in.sda_low = 1'b1; end
         PH_RESTART: begin res_in.scl = 1'b0; res_in.sda_low = 1'b0; end
         PH_HDR_LO, PH_DAT_LO: begin
            res_in.scl = 1'b0; res_in.sda_low = ~shift_ff[7];
         end
         PH_HDR_HI, PH_DAT_HI: begin
            res_in.scl = 1'b1; res_in.sda_low = ~shift_ff[7];
         end
         PH_HACK_LO, PH_DACK_LO, PH_RX_LO: begin
            res_in.scl = 1'b0; res_in.sda_low = 1'b0;
         end
         PH_MACK_LO: begin res_in.scl = 1'b0; res_in.sda_low = more; end
         PH_MACK_HI: begin res_in.scl = 1'b1; res_in.sda_low = more; end
         PH_STOP_A:  begin res_in.scl = 1'b0; res_in.sda_low = 1'b1; end
         PH_STOP_B:  begin res_in.scl = 1'b1; res_in.sda_low = 1'b1; end
         default:    begin res_in.scl = 1'b1; res_in.sda_low = 1'b0; end
      endcase

      if (acc) begin
         if (op == OP_PUSH && !busy) begin
            // append to the write buffer
            if (room) begin
               wbuf_we = 1'b1;
               fill_in = fill_ff + 8'd1;
            end
         end else if (op == OP_START && !busy) begin
            // latch the request and open with a start condition
            dir_in      = is_rd;
            addr_in     = reg_addr;
            len_in      = length;
            if (!is_rd) begin
               fill_in = 8'd0;
            end
            shift_in    = {dev_addr_ff, 1'b0};
            tick_in     = 8'd0;
            bit_in      = 4'd0;
            byte_cnt_in = 8'd0;
            ack_wait_in = 8'd0;
            fail_in     = 1'b0;
            phase_in    = PH_START_A;
         end else if (op == OP_TICK && busy) begin
            if (phase_ff == PH_HACK_HI || phase_ff == PH_DACK_HI) begin
               // acknowledge wait: sample SDA each tick
               tick_in = 8'd0;
               if (!sda) begin
                  if (phase_ff == PH_HACK_HI) begin
                     case (byte_cnt_ff)
                        8'd0: begin
                           shift_in = addr_ff[15:8]; byte_cnt_in = 8'd1;
                           phase_in = PH_HDR_LO;
                        end
                        8'd1: begin
                           shift_in = addr_ff[7:0]; byte_cnt_in = 8'd2;
                           phase_in = PH_HDR_LO;
                        end
                        8'd2: begin
                           if (len_ff == 8'd0) begin
                              fail_in = 1'b0; phase_in = PH_STOP_A;
                           end else if (dir_ff) begin
                              shift_in = {dev_addr_ff, 1'b1}; byte_cnt_in = 8'd3;
                              phase_in = PH_RESTART;
                           end else begin
                              byte_cnt_in = 8'd0; shift_in = wbuf_rdata_ff;
                              phase_in = PH_DAT_LO;
                           end
                        end
                        default: begin
                           byte_cnt_in = 8'd0; shift_in = 8'd0;
                           phase_in = PH_RX_LO;
                        end
                     endcase
                  end else begin
                     byte_cnt_in = bc_nxt;
                     if (bc_nxt >= len_ff) begin
                        fail_in = 1'b0; phase_in = PH_STOP_A;
                     end else begin
                        shift_in = wbuf_rdata_ff; phase_in = PH_DAT_LO;
                     end
                  end
               end else if (tries > {1'b0, ack_to_ff}) begin
                  // no acknowledge in time: stop with an error
                  fail_in  = 1'b1;
                  phase_in = PH_STOP_A;
               end else begin
                  ack_wait_in = tries[7:0];
               end
            end else if (tick_nxt < {1'b0, span}) begin
               tick_in = tick_nxt[7:0];
            end else begin
               // end of a half period: move to the next bus step
               tick_in = 8'd0;
               unique case (phase_ff)
                  PH_START_A: phase_in = PH_START_B;
                  PH_START_B: begin bit_in = 4'd0; phase_in = PH_HDR_LO; end
                  PH_RESTART: phase_in = PH_START_A;
                  PH_HDR_LO:  phase_in = PH_HDR_HI;
                  PH_DAT_LO:  phase_in = PH_DAT_HI;
                  PH_HDR_HI, PH_DAT_HI: begin
                     shift_in = {shift_ff[6:0], 1'b0};
                     if (bit_nxt >= 4'd8) begin
                        bit_in   = 4'd0;
                        phase_in = (phase_ff == PH_HDR_HI) ? PH_HACK_LO : PH_DACK_LO;
                     end else begin
                        bit_in   = bit_nxt;
                        phase_in = (phase_ff == PH_HDR_HI) ? PH_HDR_LO : PH_DAT_LO;
                     end
                  end
                  PH_HACK_LO: begin ack_wait_in = 8'd0; phase_in = PH_HACK_HI; end
                  PH_DACK_LO: begin ack_wait_in = 8'd0; phase_in = PH_DACK_HI; end
                  PH_RX_LO:   phase_in = PH_RX_HI;
                  PH_RX_HI: begin
                     shift_in = rx_shift;
                     if (bit_nxt >= 4'd8) begin
                        bit_in            = 4'd0;
                        res_in.read_valid = 1'b1;
                        res_in.read_byte  = rx_shift;
                        res_in.read_last  = ~more;
                        phase_in          = PH_MACK_LO;
                     end else begin
                        bit_in   = bit_nxt;
                        phase_in = PH_RX_LO;
                     end
                  end
                  PH_MACK_LO: phase_in = PH_MACK_HI;
                  PH_MACK_HI: begin
                     if (more) begin
                        byte_cnt_in = bc_nxt;
                        shift_in    = 8'd0;
                        phase_in    = PH_RX_LO;
                     end else begin
                        fail_in  = 1'b0;
                        phase_in = PH_STOP_A;
                     end
                  end
                  PH_STOP_A: phase_in = PH_STOP_B;
                  PH_STOP_B: phase_in = PH_STOP_C;
                  PH_STOP_C: begin
                     res_in.done_res = 1'b1;
                     res_in.error    = fail_ff;
                     phase_in        = PH_IDLE;
                  end
                  default: phase_in = PH_IDLE;
               endcase
            end
         end
      end
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         tick_ff     <= 8'd0;
         bit_ff      <= 4'd0;
         byte_cnt_ff <= 8'd0;
         ack_wait_ff <= 8'd0;
         fill_ff     <= 8'd0;
         fail_ff     <= 1'b0;
         shift_ff    <= 8'd0;
         addr_ff     <= 16'd0;
         len_ff      <= 8'd0;
         dir_ff      <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         tick_ff     <= tick_in;
         bit_ff      <= bit_in;
         byte_cnt_ff <= byte_cnt_in;
         ack_wait_ff <= ack_wait_in;
         fill_ff     <= fill_in;
         fail_ff     <= fail_in;
         shift_ff    <= shift_in;
         addr_ff     <= addr_in;
         len_ff      <= len_in;
         dir_ff      <= dir_in;
      end
   end

   // ---------------- result queue: output register plus skid entry ----------------
   logic pop;
   assign pop = out_v_ff & rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (pop) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= acc;
         end else begin
            out_v_ff  <= acc;
         end
      end else if (!out_v_ff) begin
         out_v_ff <= acc;
      end else if (acc) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (skid_v_ff) begin
            out_ff <= skid_ff;
            if (acc) begin
               skid_ff <= res_in;
            end
         end else if (acc) begin
            out_ff <= res_in;
         end
      end else if (!out_v_ff) begin
         if (acc) begin
            out_ff <= res_in;
         end
      end else if (acc) begin
         skid_ff <= res_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {3'b000, out_ff.error, out_ff.done_res, out_ff.read_byte,
                        out_ff.busy_res, out_ff.sda_low, out_ff.scl};
   assign rsp_tuser  = out_ff.read_valid;
   assign rsp_tlast  = out_ff.read_last;

`ifndef SYNTHESIS
   // skid entry is only used behind a full output register
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry valid without output entry");

   // buffer fill never passes its depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, fill_ff} <= MAX_LEN_W)
      else $error("write buffer fill count overflow");

   // bit counter stays inside a byte
   a_bit_bound: assert property (@(posedge clock) disable iff (reset)
      bit_ff < 4'd8)
      else $error("bit counter out of range");

   // a completed stop returns the sequencer to idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      acc && res_in.done_res |=> phase_ff == PH_IDLE)
      else $error("done without return to idle");

   // a received byte is followed by the master acknowledge step
   a_rx_mack: assert property (@(posedge clock) disable iff (reset)
      acc && res_in.read_valid |=> phase_ff == PH_MACK_LO)
      else $error("received byte not followed by master ack");
`endif

endmodule

### bench/i2c_register_transaction_master_test.sv
// Self-checking bench for the I2C register transaction master: a directed
// table, then random bus traffic answered by a small slave model and checked
// against an in-bench copy of the sequencer. Depends on i2crtm_pkg and the RTL.
`timescale 1ns / 1ps

module i2c_register_transaction_master_test;
   import i2crtm_pkg::*;

   localparam logic [1:0] OP_NONE = 2'd3;   // unused opcode, block ignores it
   localparam int BUF_DEPTH = MAX_LEN_DEF;
   localparam int HOLD_CYCLES = 80;
   // idle lines: scl high, sda released, nothing reported
   localparam rsp_item_type IDLE_LINES = '{read_last: 1'b0, read_valid: 1'b0,
      error: 1'b0, done_res: 1'b0, read_byte: 8'h00, busy_res: 1'b0,
      sda_low: 1'b0, scl: 1'b1};

   typedef struct {
      logic [1:0]  opcode;
      logic        sda;
      logic [7:0]  wbyte;
      logic        is_read;
      logic [15:0] reg_addr;
      logic [7:0]  length;
   } bus_req_type;

   typedef enum logic {ROW_ITEM, ROW_RUN} row_kind_type;

   typedef struct {
      row_kind_type kind;
      bus_req_type  item;
      int           refuse;   // ack slot the slave refuses in a run row
      logic         typed;    // result is the idle-lines value
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = OP_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic        csr_pready;

   i2c_register_transaction_master uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sequencer copy
   logic [6:0]  m_dev;
   logic [7:0]  m_half;
   logic [7:0]  m_ack_to;
   logic [4:0]  m_phase;
   logic [7:0]  m_ticks;
   logic [3:0]  m_bits;
   logic [7:0]  m_shift;
   logic [7:0]  m_bytes;
   logic [7:0]  m_ack_wait;
   logic [15:0] m_addr;
   logic [7:0]  m_len;
   logic        m_dir;
   logic [7:0]  m_fill;
   logic        m_fail;
   logic [7:0]  m_buf [0:BUF_DEPTH-1];

   // bench bookkeeping
   rsp_item_type owed_rsp[$];
   plan_row_type plan[$];
   int buf_known = 0;        // buffer entries written at least once
   int refuse_slot = -1;
   int ack_hold = 0;
   int send_idle_pct = 21;
   int recv_idle_pct = 57;
   int items_sent = 0;
   int results_seen = 0;
   int mismatches = 0;
   int txn_done = 0;
   int txn_failed = 0;
   int bytes_read = 0;
   int hold_left = 0;

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (mismatches < 50)
         $display("MISMATCH %s at result %0d: got %0h, want %0h",
                  what, results_seen, got, want);
      mismatches++;
   endtask

   function automatic logic more_to_read();
      return int'(m_bytes) + 1 < int'(m_len);
   endfunction

   // {scl, sda_low} driven while in the current phase
   function automatic logic [1:0] line_levels();
      logic msb_low;
      msb_low = ~m_shift[7];
      case (m_phase)
         PH_START_B: return 2'b11;
         PH_RESTART: return 2'b00;
         PH_HDR_LO, PH_DAT_LO: return {1'b0, msb_low};
         PH_HDR_HI, PH_DAT_HI: return {1'b1, msb_low};
         PH_HACK_LO, PH_DACK_LO, PH_RX_LO: return 2'b00;
         PH_MACK_LO: return {1'b0, more_to_read()};
         PH_MACK_HI: return {1'b1, more_to_read()};
         PH_STOP_A: return 2'b01;
         PH_STOP_B: return 2'b11;
         default: return 2'b10;
      endcase
   endfunction

   function automatic void stop_begin(input logic failed);
      m_fail = failed;
      m_phase = PH_STOP_A;
      m_ticks = 0;
   endfunction

   // slave acked a header byte: device address, address high/low, read address
   function automatic void header_acked();
      case (m_bytes)
         0: begin
            m_shift = m_addr[15:8]; m_bytes = 1; m_phase = PH_HDR_LO;
         end
         1: begin
            m_shift = m_addr[7:0]; m_bytes = 2; m_phase = PH_HDR_LO;
         end
         2: begin
            if (m_len == 0) begin
               stop_begin(1'b0);
            end else if (m_dir) begin
               m_shift = {m_dev, 1'b1}; m_bytes = 3; m_phase = PH_RESTART;
            end else begin
               m_bytes = 0; m_shift = m_buf[0]; m_phase = PH_DAT_LO;
            end
         end
         default: begin
            m_bytes = 0; m_shift = 0; m_phase = PH_RX_LO;
         end
      endcase
   endfunction

   function automatic void data_acked();
      m_bytes++;
      if (m_bytes >= m_len) begin
         stop_begin(1'b0);
      end else begin
         m_shift = m_buf[m_bytes];
         m_phase = PH_DAT_LO;
      end
   endfunction

   // one SDA sample while SCL is high waiting for an acknowledge
   function automatic void ack_sample(input logic sda, input logic hdr);
      int tries;
      m_ticks = 0;
      if (!sda) begin
         if (hdr) header_acked();
         else data_acked();
         return;
      end
      tries = int'(m_ack_wait) + 1;
      if (tries > int'(m_ack_to)) stop_begin(1'b1);
      else m_ack_wait = 8'(tries);
   endfunction

   // one tick of a running transaction; returns the read and done events
   function automatic rsp_item_type bus_advance(input logic sda);
      rsp_item_type ev;
      int span;
      logic hdr;
      ev = '0;
      span = (m_half == 0) ? 1 : int'(m_half);
      if (m_phase == PH_HACK_HI || m_phase == PH_DACK_HI) begin
         ack_sample(sda, m_phase == PH_HACK_HI);
         return ev;
      end
      if (int'(m_ticks) + 1 < span) begin
         m_ticks++;
         return ev;
      end
      m_ticks = 0;
      case (m_phase)
         PH_START_A: m_phase = PH_START_B;
         PH_START_B: begin
            m_bits = 0; m_phase = PH_HDR_LO;
         end
         PH_RESTART: m_phase = PH_START_A;
         PH_HDR_LO: m_phase = PH_HDR_HI;
         PH_DAT_LO: m_phase = PH_DAT_HI;
         PH_HDR_HI, PH_DAT_HI: begin
            hdr = (m_phase == PH_HDR_HI);
            m_shift = m_shift << 1;
            m_bits++;
            if (m_bits >= 8) begin
               m_bits = 0;
               m_phase = hdr ? PH_HACK_LO : PH_DACK_LO;
            end else begin
               m_phase = hdr ? PH_HDR_LO : PH_DAT_LO;
            end
         end
         PH_HACK_LO: begin
            m_ack_wait = 0; m_phase = PH_HACK_HI;
         end
         PH_DACK_LO: begin
            m_ack_wait = 0; m_phase = PH_DACK_HI;
         end
         PH_RX_LO: m_phase = PH_RX_HI;
         PH_RX_HI: begin
            m_shift = {m_shift[6:0], sda};
            m_bits++;
            if (m_bits >= 8) begin
               m_bits = 0;
               ev.read_valid = 1'b1;
               ev.read_byte = m_shift;
               ev.read_last = !more_to_read();
               bytes_read++;
               m_phase = PH_MACK_LO;
            end else begin
               m_phase = PH_RX_LO;
            end
         end
         PH_MACK_LO: m_phase = PH_MACK_HI;
         PH_MACK_HI: begin
            if (more_to_read()) begin
               m_bytes++; m_shift = 0; m_phase = PH_RX_LO;
            end else begin
               stop_begin(1'b0);
            end
         end
         PH_STOP_A: m_phase = PH_STOP_B;
         PH_STOP_B: m_phase = PH_STOP_C;
         PH_STOP_C: begin
            ev.done_res = 1'b1;
            ev.error = m_fail;
            txn_done++;
            if (m_fail) txn_failed++;
            m_phase = PH_IDLE;
         end
         default: m_phase = PH_IDLE;
      endcase
      return ev;
   endfunction

   // result of one accepted item, updating the sequencer copy
   function automatic rsp_item_type bus_step(input bus_req_type it);
      rsp_item_type r;
      rsp_item_type ev;
      logic busy;
      logic [1:0] lines;
      busy = (m_phase != PH_IDLE);
      lines = line_levels();
      r = '0;
      r.scl = lines[1];
      r.sda_low = lines[0];
      r.busy_res = busy;
      if (it.opcode == OP_PUSH && !busy) begin
         if (int'(m_fill) < BUF_DEPTH && m_fill < 8'd255) begin
            m_buf[m_fill] = it.wbyte;
            m_fill++;
            if (int'(m_fill) > buf_known) buf_known = int'(m_fill);
         end
      end else if (it.opcode == OP_START && !busy) begin
         m_dir = it.is_read;
         m_addr = it.reg_addr;
         m_len = it.length;
         if (!m_dir) m_fill = 0;
         m_shift = {m_dev, 1'b0};
         m_ticks = 0; m_bits = 0; m_bytes = 0;
         m_ack_wait = 0; m_fail = 0;
         m_phase = PH_START_A;
      end else if (it.opcode == OP_TICK && busy) begin
         ev = bus_advance(it.sda);
         r.read_valid = ev.read_valid;
         r.read_byte = ev.read_byte;
         r.read_last = ev.read_last;
         r.done_res = ev.done_res;
         r.error = ev.error;
      end
      return r;
   endfunction

   // slave side of the bus: acks after a short random delay unless told to
   // refuse one slot, random data bits otherwise
   function automatic logic slave_sda();
      int slot;
      if (m_phase == PH_HACK_HI || m_phase == PH_DACK_HI) begin
         slot = (m_phase == PH_HACK_HI) ? int'(m_bytes) : 4 + int'(m_bytes);
         if (slot == refuse_slot) return 1'b1;
         if (ack_hold > 0) begin
            ack_hold--;
            return 1'b1;
         end
         ack_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
         return 1'b0;
      end
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic bus_req_type noise_item();
      bus_req_type it;
      it.opcode = 2'($urandom_range(0, 3));
      it.sda = 1'($urandom_range(0, 1));
      it.wbyte = 8'($urandom_range(0, 255));
      it.is_read = 1'($urandom_range(0, 1));
      it.reg_addr = 16'($urandom_range(0, 65535));
      it.length = 8'($urandom_range(0, 255));
      return it;
   endfunction

   // offer one item after a random gap, wait for acceptance, predict
   task automatic send_item(input bus_req_type it, input logic typed);
      rsp_item_type r;
      while (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, it.length, it.reg_addr, it.is_read, it.wbyte, it.sda};
      req_tuser <= it.opcode;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = bus_step(it);
      owed_rsp.push_back(typed ? IDLE_LINES : r);
      items_sent++;
   endtask

   // tick the bus until the transaction ends, with stray requests mixed in
   task automatic run_until_idle();
      bus_req_type it;
      while (m_phase != PH_IDLE) begin
         it = noise_item();
         if ($urandom_range(0, 19) != 0 || it.opcode == OP_TICK) begin
            it.opcode = OP_TICK;
            it.sda = slave_sda();
         end
         send_item(it, 1'b0);
      end
   endtask

   task automatic run_transaction(input logic rd, input int len, input int pushes,
                                  input int refuse);
      bus_req_type it;
      refuse_slot = refuse;
      ack_hold = 0;
      repeat (pushes) begin
         it = noise_item();
         it.opcode = OP_PUSH;
         send_item(it, 1'b0);
      end
      // a write may only send entries that were written at some point
      if (!rd && len > buf_known) len = buf_known;
      it = noise_item();
      it.opcode = OP_START;
      it.is_read = rd;
      it.length = 8'(len);
      send_item(it, 1'b0);
      run_until_idle();
   endtask

   task automatic csr_access(input logic wr, input logic [1:0] idx,
                             input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wr ? value : 32'd0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (!wr && csr_prdata !== value)
         report_mismatch("register readback", csr_prdata[15:0], value[15:0]);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // only called with the sequencer idle; waits until every result is delivered
   task automatic configure(input logic [6:0] dev, input logic [7:0] half,
                            input logic [7:0] ack_to);
      req_tvalid <= 1'b0;
      while (owed_rsp.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_access(1'b1, REG_DEV_ADDR, {25'd0, dev});
      csr_access(1'b1, REG_HALF_PER, {24'd0, half});
      csr_access(1'b1, REG_ACK_TO, {24'd0, ack_to});
      m_dev = dev;
      m_half = half;
      m_ack_to = ack_to;
      csr_access(1'b0, REG_DEV_ADDR, {25'd0, dev});
      csr_access(1'b0, REG_HALF_PER, {24'd0, half});
      csr_access(1'b0, REG_ACK_TO, {24'd0, ack_to});
   endtask

   task automatic random_traffic(input int budget);
      bus_req_type it;
      int stop_at;
      int len;
      int refuse;
      logic rd;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         // a little line noise while idle
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               it = noise_item();
               it.opcode = $urandom_range(0, 1) ? OP_TICK : OP_NONE;
               send_item(it, 1'b0);
            end
         end
         rd = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0: len = 0;
            8, 9: len = $urandom_range(4, 10);
            default: len = $urandom_range(1, 3);
         endcase
         refuse = -1;
         if ($urandom_range(0, 4) == 0)
            refuse = rd ? $urandom_range(0, 3) : $urandom_range(0, 4 + len);
         run_transaction(rd, len, $urandom_range(0, 4), refuse);
      end
   endtask

   task automatic add_item(input logic [1:0] op, input logic sda, input logic [7:0] wb,
                           input logic rd, input logic [15:0] addr,
                           input logic [7:0] len, input logic typed);
      plan_row_type row;
      row.kind = ROW_ITEM;
      row.item = '{opcode: op, sda: sda, wbyte: wb, is_read: rd, reg_addr: addr,
                   length: len};
      row.refuse = -1;
      row.typed = typed;
      plan.push_back(row);
   endtask

   task automatic add_run(input int refuse);
      plan_row_type row;
      row.kind = ROW_RUN;
      row.item = '{opcode: OP_TICK, sda: 1'b0, wbyte: 8'h00, is_read: 1'b0,
                   reg_addr: 16'h0000, length: 8'h00};
      row.refuse = refuse;
      row.typed = 1'b0;
      plan.push_back(row);
   endtask

   // result side: check in order, random stalls, one long hold-off now and then
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (owed_rsp.size() == 0) begin
            report_mismatch("result with none expected", rsp_tdata, 16'h0);
         end else begin
            want = owed_rsp.pop_front();
            results_seen++;
            if (rsp_tdata[0] !== want.scl)
               report_mismatch("scl", 16'(rsp_tdata[0]), 16'(want.scl));
            if (rsp_tdata[1] !== want.sda_low)
               report_mismatch("sda_low", 16'(rsp_tdata[1]), 16'(want.sda_low));
            if (rsp_tdata[2] !== want.busy_res)
               report_mismatch("busy_res", 16'(rsp_tdata[2]), 16'(want.busy_res));
            if (rsp_tdata[10:3] !== want.read_byte)
               report_mismatch("read_byte", 16'(rsp_tdata[10:3]), 16'(want.read_byte));
            if (rsp_tdata[11] !== want.done_res)
               report_mismatch("done_res", 16'(rsp_tdata[11]), 16'(want.done_res));
            if (rsp_tdata[12] !== want.error)
               report_mismatch("error", 16'(rsp_tdata[12]), 16'(want.error));
            if (rsp_tuser !== want.read_valid)
               report_mismatch("read_valid", 16'(rsp_tuser), 16'(want.read_valid));
            if (rsp_tlast !== want.read_last)
               report_mismatch("read_last", 16'(rsp_tlast), 16'(want.read_last));
            if (results_seen % 1500 == 400) hold_left = HOLD_CYCLES;
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(1, 100) > recv_idle_pct);
      end
   end

   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int waited;
      m_dev = DEV_ADDR_RST;
      m_half = HALF_PER_RST;
      m_ack_to = ACK_TO_RST;
      m_phase = PH_IDLE;
      m_ticks = 0; m_bits = 0; m_shift = 0; m_bytes = 0; m_ack_wait = 0;
      m_addr = 0; m_len = 0; m_dir = 0; m_fill = 0; m_fail = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, REG_DEV_ADDR, {25'd0, DEV_ADDR_RST});
      csr_access(1'b0, REG_HALF_PER, {24'd0, HALF_PER_RST});
      csr_access(1'b0, REG_ACK_TO, {24'd0, ACK_TO_RST});

      // directed table on a fast bus with a short ack timeout
      configure(DEV_ADDR_RST, 8'd1, 8'd3);
      add_item(OP_TICK,  1'b0, 8'h00, 1'b0, 16'h0000, 8'd0,   1'b1);  // idle tick
      add_item(OP_TICK,  1'b1, 8'hFF, 1'b1, 16'hFFFF, 8'd255, 1'b1);
      add_item(OP_NONE,  1'b1, 8'hFF, 1'b1, 16'hFFFF, 8'd255, 1'b1);
      add_item(OP_PUSH,  1'b0, 8'h00, 1'b0, 16'h0000, 8'd0,   1'b1);
      add_item(OP_PUSH,  1'b0, 8'hFF, 1'b0, 16'h0000, 8'd0,   1'b1);
      add_item(OP_PUSH,  1'b0, 8'h5A, 1'b0, 16'h0000, 8'd0,   1'b1);
      add_item(OP_START, 1'b0, 8'h00, 1'b0, 16'hFFFF, 8'd3,   1'b1);
      // requests while busy are dropped
      add_item(OP_PUSH,  1'b0, 8'h11, 1'b0, 16'h0000, 8'd0,   1'b0);
      add_item(OP_START, 1'b1, 8'h00, 1'b1, 16'h1111, 8'd9,   1'b0);
      add_item(OP_NONE,  1'b0, 8'hC3, 1'b0, 16'h2222, 8'd1,   1'b0);
      add_run(-1);
      add_item(OP_START, 1'b0, 8'h00, 1'b1, 16'h0000, 8'd2,   1'b1);
      add_run(-1);
      // zero length: stop right after the register address, no repeated start
      add_item(OP_START, 1'b0, 8'h00, 1'b1, 16'h8001, 8'd0,   1'b1);
      add_run(-1);
      add_item(OP_START, 1'b0, 8'h00, 1'b0, 16'h7FFE, 8'd0,   1'b1);
      add_run(-1);
      // length beyond the fill count, slave refuses the second data byte
      add_item(OP_START, 1'b0, 8'h00, 1'b0, 16'h1234, 8'd2,   1'b1);
      add_run(5);
      // slave refuses the read address after the repeated start
      add_item(OP_START, 1'b0, 8'h00, 1'b1, 16'hA55A, 8'd1,   1'b1);
      add_run(3);
      add_item(OP_TICK,  1'b1, 8'h00, 1'b0, 16'h0000, 8'd0,   1'b1);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_RUN) begin
            refuse_slot = plan[i].refuse;
            ack_hold = 0;
            run_until_idle();
         end else begin
            send_item(plan[i].item, plan[i].typed);
         end
      end

      // zero half period and zero timeout, sender light / receiver heavy idling
      configure(7'd0, 8'd0, 8'd0);
      random_traffic(200);

      send_idle_pct = 57;
      recv_idle_pct = 21;
      configure(7'd127, 8'd1, 8'd255);
      random_traffic(200);

      // full buffer and the longest length, cut short by a refused ack,
      // then random with no idling
      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(7'($urandom_range(1, 126)), 8'd1, 8'd1);
      run_transaction(1'b0, 255, 256, 5);
      run_transaction(1'b1, 255, 0, 3);
      random_traffic(80);

      // slower bus, slave refuses the device address
      configure(7'($urandom_range(0, 127)), 8'd3, 8'($urandom_range(0, 255)));
      run_transaction(1'($urandom_range(0, 1)), $urandom_range(0, 2), 0, 0);

      req_tvalid <= 1'b0;
      waited = 0;
      while (owed_rsp.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (5) @(posedge clock);
      if (owed_rsp.size() != 0)
         report_mismatch("results never delivered", 16'(owed_rsp.size()), 16'h0);

      $display("Run covered %0d items and %0d checked results over five bus settings.",
               items_sent, results_seen);
      $display("Transactions finished: %0d (%0d aborted on a missing ack), %0d bytes read.",
               txn_done, txn_failed, bytes_read);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
